// File: sv/sequence_loss_monitor_assert.svh
// Assertion macros shared by the monitor RTL.
`ifndef SEQUENCE_LOSS_MONITOR_ASSERT_SVH
`define SEQUENCE_LOSS_MONITOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SLM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define SLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/slm_pkg.sv
`default_nettype none
package slm_pkg;
  localparam int unsigned PairW   = 16;
  localparam int unsigned SeqW    = 8;
  localparam int unsigned CntW    = 32;
  localparam int unsigned PctW    = 16;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned DivW    = 33;
  localparam int unsigned DivBits = 26;
  localparam logic [PctW-1:0] PercentQ9 = 16'd51200;
  localparam logic [4:0] ReportMask = 5'h1F;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [7:0]       source_system;
    logic [7:0]       source_component;
    logic [SeqW-1:0]  sequence_req;
    logic             vehicle_known;
  } item_t;

  typedef struct packed {
    logic [SeqW-1:0] lost_now;
    logic [CntW-1:0] received_total;
    logic [CntW-1:0] lost_total;
    logic [PctW-1:0] loss_percent;
    logic            report_due;
  } result_t;
endpackage
`default_nettype wire

// File: sv/slm_if.sv
`default_nettype none
interface slm_in_if;
  logic            valid;
  logic            ready;
  slm_pkg::item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface slm_out_if;
  logic             valid;
  logic             ready;
  slm_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/sequence_loss_monitor.sv
// Each item passes through the read, count, multiply, divide and done states; the
// restoring divider retires one quotient bit per cycle over a 59-bit dividend.
// Items are handled one at a time and are taken only while idle. A new item is taken while the result
// waits, and the last step holds only while an older result is still pending.
// After reset a clearing pass sweeps the seen flags of the whole pair table; counters
// and running loss reset to zero at once.
`default_nettype none
`include "sequence_loss_monitor_assert.svh"
module sequence_loss_monitor #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  slm_in_if.sink    in_i,
  slm_out_if.source out_o
);
  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCount = 3'd3;
  localparam logic [2:0] StMul   = 3'd4;
  localparam logic [2:0] StDiv   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [slm_pkg::PairW-1:0] clr_q;

  // Pair table: last sequence and seen flag in one memory word.
  logic [slm_pkg::SeqW:0] pair_mem [2**slm_pkg::PairW];
  logic [slm_pkg::SeqW:0] pair_rd_q;

  logic [slm_pkg::CntW-1:0] rcv_q [CHANNELS];
  logic [slm_pkg::CntW-1:0] lst_q [CHANNELS];
  logic [slm_pkg::PctW-1:0] run_q [CHANNELS];

  slm_pkg::item_t item_q;
  logic [ChIdxW-1:0] ch_q;
  logic [slm_pkg::SeqW-1:0] lost_q;
  logic [slm_pkg::CntW-1:0] rcv_n_q, lst_n_q;
  logic [slm_pkg::DivBits+slm_pkg::DivW-1:0] num_q;
  logic [slm_pkg::DivW-1:0] den_q, rem_q;
  logic [5:0] bit_q;

  logic out_valid_q;
  slm_pkg::result_t out_q;

  logic in_xfer, out_xfer, done_go;
  logic [slm_pkg::PairW-1:0] pair_idx;
  logic [ChIdxW-1:0] ch_sel;
  logic [slm_pkg::DivW+1:0] trial;
  logic [slm_pkg::DivW:0] rem_sh;
  logic [slm_pkg::SeqW-1:0] gap;
  logic [slm_pkg::CntW:0] rcv_inc, lst_add;
  logic [slm_pkg::PctW:0] run_sum;
  logic [slm_pkg::PctW-1:0] ratio;

  assign in_i.ready    = (state_q == StIdle);
  assign in_xfer       = in_i.valid && in_i.ready;
  assign out_xfer      = out_valid_q && out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign pair_idx      = {item_q.source_system, item_q.source_component};

  // The last step may finish once the output register is free or being drained.
  assign done_go = (state_q == StDone) && (!out_valid_q || out_o.ready);

  // Out-of-range channels fold onto channel zero.
  always_comb begin
    ch_sel = '0;
    if ({30'd0, in_i.payload.channel} < CHANNELS) begin
      ch_sel = ChIdxW'(in_i.payload.channel);
    end
  end

  // Gap and saturating counter updates.
  assign gap     = item_q.sequence_req - pair_rd_q[slm_pkg::SeqW-1:0] - 8'd1;
  assign rcv_inc = {1'b0, rcv_q[ch_q]} + 33'd1;
  assign lst_add = {1'b0, lst_q[ch_q]} + {25'd0, lost_q};

  // One restoring divide step; the shifted remainder keeps its top bit.
  assign rem_sh = {rem_q, num_q[slm_pkg::DivBits+slm_pkg::DivW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b0, den_q};

  // Quotient clamp and averaging with the old running value.
  always_comb begin
    ratio = num_q[slm_pkg::PctW-1:0];
    if (num_q[slm_pkg::DivBits+slm_pkg::DivW-1:slm_pkg::PctW] != '0 ||
        num_q[slm_pkg::PctW-1:0] > slm_pkg::PercentQ9) begin
      ratio = slm_pkg::PercentQ9;
    end
  end
  assign run_sum = {1'b0, ratio} + {1'b0, run_q[ch_q]};

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == '1) state_d = StIdle;
      StIdle:  if (in_xfer) state_d = StRead;
      StRead:  state_d = StCount;
      StCount: state_d = StMul;
      StMul:   state_d = StDiv;
      StDiv:   if (bit_q == 6'd0) state_d = StDone;
      StDone:  if (done_go) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        rcv_q[i] <= '0;
        lst_q[i] <= '0;
        run_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (state_q == StCount) begin
        rcv_q[ch_q] <= rcv_inc[slm_pkg::CntW] ? '1 : rcv_inc[slm_pkg::CntW-1:0];
        lst_q[ch_q] <= lst_add[slm_pkg::CntW] ? '1 : lst_add[slm_pkg::CntW-1:0];
      end
      if (done_go) begin
        run_q[ch_q] <= run_sum[slm_pkg::PctW:1];
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pair table port: one read on accept, one write afterwards or clear.
  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      pair_mem[clr_q] <= '0;
    end else if (state_q == StRead) begin
      pair_mem[pair_idx] <= {1'b1, item_q.sequence_req};
    end
    if (in_xfer) begin
      pair_rd_q <= pair_mem[{in_i.payload.source_system, in_i.payload.source_component}];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_i.payload;
      ch_q   <= ch_sel;
    end
    if (state_q == StRead) begin
      lost_q <= pair_rd_q[slm_pkg::SeqW] ? gap : '0;
    end
    if (state_q == StCount) begin
      rcv_n_q <= rcv_inc[slm_pkg::CntW] ? '1 : rcv_inc[slm_pkg::CntW-1:0];
      lst_n_q <= lst_add[slm_pkg::CntW] ? '1 : lst_add[slm_pkg::CntW-1:0];
    end
    if (state_q == StMul) begin
      num_q <= {27'd0, lst_n_q} * {43'd0, slm_pkg::PercentQ9};
      den_q <= {1'b0, rcv_n_q} + {1'b0, lst_n_q};
      rem_q <= '0;
      bit_q <= 6'(slm_pkg::DivBits + slm_pkg::DivW - 1);
    end
    if (state_q == StDiv) begin
      bit_q <= bit_q - 6'd1;
      if (!trial[slm_pkg::DivW+1]) begin
        rem_q <= trial[slm_pkg::DivW-1:0];
        num_q <= {num_q[slm_pkg::DivBits+slm_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[slm_pkg::DivW-1:0];
        num_q <= {num_q[slm_pkg::DivBits+slm_pkg::DivW-2:0], 1'b0};
      end
    end
    if (done_go) begin
      out_q.lost_now       <= lost_q;
      out_q.received_total <= rcv_n_q;
      out_q.lost_total     <= lst_n_q;
      out_q.loss_percent   <= run_sum[slm_pkg::PctW:1];
      out_q.report_due     <= item_q.vehicle_known &&
                              ((rcv_n_q[4:0] & slm_pkg::ReportMask) == 5'd0);
    end
  end

  `SLM_ASSERT_IMP(a_no_accept_busy, state_q != StIdle, !in_i.ready, "ready while busy")
  `SLM_ASSERT_NEXT(a_done_valid, state_q == StDone, out_valid_q, "result not raised")
  `SLM_ASSERT_IMP(a_pct_range, out_valid_q, out_q.loss_percent <= slm_pkg::PercentQ9, "pct")
  `SLM_ASSERT_NEXT(a_accept_read, in_xfer, state_q == StRead, "accept did not start item")
endmodule
`default_nettype wire

// File: dv/sequence_loss_monitor_test.sv
`timescale 1ns / 1ps
module sequence_loss_monitor_test;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned RandomItems = 1700;

  logic clk_i;
  logic rst_ni;

  slm_in_if in_i ();
  slm_out_if out_o ();

  sequence_loss_monitor #(.CHANNELS(NumChannels)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i.sink),
    .out_o (out_o.source)
  );

  // Shadow copy of the monitor state.
  logic [slm_pkg::SeqW-1:0] shadow_last_seq[int unsigned];
  logic [slm_pkg::CntW-1:0] shadow_received[NumChannels];
  logic [slm_pkg::CntW-1:0] shadow_lost[NumChannels];
  logic [slm_pkg::PctW-1:0] shadow_running[NumChannels];

  slm_pkg::result_t pending_results[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit timed_out;
  bit stimulus_done;

  // Directed rows; a row with has_check set also carries a hand-typed result.
  typedef struct {
    slm_pkg::item_t   pkt;
    bit               has_check;
    slm_pkg::result_t want;
  } directed_row_t;

  directed_row_t directed_rows[$];

  // Saturating 32-bit addition.
  function automatic logic [slm_pkg::CntW-1:0] add_saturated(logic [slm_pkg::CntW-1:0] a,
                                                             logic [slm_pkg::CntW-1:0] b);
    logic [slm_pkg::CntW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[slm_pkg::CntW] ? {slm_pkg::CntW{1'b1}} : sum[slm_pkg::CntW-1:0];
  endfunction

  // Work out the result for one packet header and advance the shadow state.
  function automatic slm_pkg::result_t track_packet(slm_pkg::item_t pkt);
    slm_pkg::result_t res;
    int unsigned ch;
    int unsigned pair;
    logic [slm_pkg::SeqW-1:0] gap;
    logic [slm_pkg::DivW-1:0] total;
    logic [63:0] ratio;
    logic [slm_pkg::PctW:0] run_sum;
    ch = (32'(pkt.channel) >= NumChannels) ? 0 : 32'(pkt.channel);
    pair = 32'({pkt.source_system, pkt.source_component});
    gap = '0;
    shadow_received[ch] = add_saturated(shadow_received[ch], 32'd1);
    if (shadow_last_seq.exists(pair)) begin
      gap = pkt.sequence_req - shadow_last_seq[pair] - 8'd1;
    end
    shadow_last_seq[pair] = pkt.sequence_req;
    shadow_lost[ch] = add_saturated(shadow_lost[ch], {24'd0, gap});
    total = {1'b0, shadow_received[ch]} + {1'b0, shadow_lost[ch]};
    ratio = (64'(shadow_lost[ch]) * 64'(slm_pkg::PercentQ9)) / 64'(total);
    if (ratio > 64'(slm_pkg::PercentQ9)) begin
      ratio = 64'(slm_pkg::PercentQ9);
    end
    run_sum = {1'b0, ratio[slm_pkg::PctW-1:0]} + {1'b0, shadow_running[ch]};
    shadow_running[ch] = run_sum[slm_pkg::PctW:1];
    res.lost_now = gap;
    res.received_total = shadow_received[ch];
    res.lost_total = shadow_lost[ch];
    res.loss_percent = shadow_running[ch];
    res.report_due = pkt.vehicle_known
        && ((shadow_received[ch][4:0] & slm_pkg::ReportMask) == 5'd0);
    return res;
  endfunction

  function automatic slm_pkg::item_t make_packet(int unsigned ch, int unsigned sys,
                                                 int unsigned comp, int unsigned seq, bit known);
    slm_pkg::item_t pkt;
    pkt.channel = ch[slm_pkg::ChanW-1:0];
    pkt.source_system = sys[7:0];
    pkt.source_component = comp[7:0];
    pkt.sequence_req = seq[slm_pkg::SeqW-1:0];
    pkt.vehicle_known = known;
    return pkt;
  endfunction

  function automatic void add_row(slm_pkg::item_t pkt, bit has_check, slm_pkg::result_t want);
    directed_row_t row;
    row.pkt = pkt;
    row.has_check = has_check;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  function automatic slm_pkg::result_t typed_result(int unsigned lost_now, int unsigned recv,
                                                    int unsigned lost, int unsigned pct,
                                                    bit report);
    slm_pkg::result_t res;
    res.lost_now = lost_now[slm_pkg::SeqW-1:0];
    res.received_total = recv;
    res.lost_total = lost;
    res.loss_percent = pct[slm_pkg::PctW-1:0];
    res.report_due = report;
    return res;
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one packet header, waiting a random gap first. Valid stays high
  // into the next call when that one has no gap.
  task automatic send_packet(slm_pkg::item_t pkt);
    int unsigned gap_cycles;
    gap_cycles = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) begin
      gap_cycles = 0;
    end
    if (gap_cycles != 0) begin
      in_i.valid <= 1'b0;
      in_i.payload <= slm_pkg::item_t'($urandom);
      repeat (gap_cycles) @(negedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.payload <= pkt;
    do @(posedge clk_i); while (!in_i.ready);
    pending_results.push_back(track_packet(pkt));
    @(negedge clk_i);
  endtask

  // Directed rows with a typed result: expectation already queued.
  task automatic send_with_given(slm_pkg::item_t pkt);
    int unsigned gap_cycles;
    gap_cycles = $urandom_range(0, 13);
    if (gap_cycles != 0) begin
      in_i.valid <= 1'b0;
      repeat (gap_cycles) @(negedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.payload <= pkt;
    do @(posedge clk_i); while (!in_i.ready);
    @(negedge clk_i);
  endtask

  // Compare one result transfer against the oldest expectation.
  task automatic check_result(slm_pkg::result_t got);
    slm_pkg::result_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("Unexpected result transfer: %p", got);
      end
    end else begin
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  endtask

  // Result side: random stalls, with stall-free stretches.
  initial begin
    int unsigned stall;
    bit calm;
    out_o.ready = 1'b0;
    calm = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 63) == 0) begin
        calm = ~calm;
      end
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        out_o.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_o.ready <= 1'b1;
      do @(posedge clk_i); while (!out_o.valid);
      check_result(out_o.payload);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    idle_cycles = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk_i);
      if ((in_i.valid && in_i.ready) || (out_o.valid && out_o.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        timed_out = 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned n;
    int unsigned ch;
    int unsigned sys;
    int unsigned comp;
    int unsigned seq;
    int unsigned next_seq[4];
    int unsigned pool_sys[4];
    int unsigned pool_comp[4];
    int unsigned pick;
    int unsigned run_len;
    slm_pkg::result_t none_res;
    rst_ni = 1'b0;
    in_i.valid = 1'b0;
    in_i.payload = '0;
    mismatch_count = 0;
    stimulus_done = 1'b0;
    none_res = '0;
    foreach (shadow_received[i]) begin
      shadow_received[i] = '0;
      shadow_lost[i] = '0;
      shadow_running[i] = '0;
    end

    // First packets from fresh pairs count no loss; then a gap, a duplicate
    // sequence, wraparound and the all-ones fields.
    add_row(make_packet(0, 0, 0, 0, 1'b1), 1'b1, typed_result(0, 1, 0, 0, 1'b0));
    add_row(make_packet(0, 0, 0, 1, 1'b0), 1'b1, typed_result(0, 2, 0, 0, 1'b0));
    add_row(make_packet(0, 0, 0, 1, 1'b0), 1'b1, typed_result(255, 3, 255, 25302, 1'b0));
    add_row(make_packet(3, 255, 255, 255, 1'b1), 1'b1, typed_result(0, 1, 0, 0, 1'b0));
    add_row(make_packet(3, 255, 255, 0, 1'b1), 1'b1, typed_result(0, 2, 0, 0, 1'b0));
    add_row(make_packet(3, 255, 255, 10, 1'b0), 1'b0, none_res);
    add_row(make_packet(1, 170, 85, 200, 1'b1), 1'b0, none_res);
    add_row(make_packet(1, 170, 85, 100, 1'b1), 1'b0, none_res);
    add_row(make_packet(2, 85, 170, 7, 1'b0), 1'b0, none_res);
    add_row(make_packet(2, 85, 170, 8, 1'b1), 1'b0, none_res);
    // Reach the report point on channel 2 with a known sender.
    for (int i = 0; i < 30; i++) begin
      add_row(make_packet(2, 85, 170, 9 + i, 1'b1), 1'b0, none_res);
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].has_check) begin
        void'(track_packet(directed_rows[i].pkt));
        pending_results.push_back(directed_rows[i].want);
        send_with_given(directed_rows[i].pkt);
      end else begin
        send_packet(directed_rows[i].pkt);
      end
    end

    // Random part: mostly in-order runs from a small pool of senders,
    // some jumps and duplicates, and some scattered fresh pairs.
    for (int i = 0; i < 4; i++) begin
      pool_sys[i] = $urandom_range(0, 255);
      pool_comp[i] = $urandom_range(0, 255);
      next_seq[i] = $urandom_range(0, 255);
    end
    n = 0;
    while (n < RandomItems) begin
      pick = $urandom_range(0, 3);
      ch = $urandom_range(0, 3);
      run_len = $urandom_range(1, 40);
      for (int k = 0; k < run_len && n < RandomItems; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            sys = $urandom_range(0, 255);
            comp = $urandom_range(0, 255);
            seq = $urandom_range(0, 255);
          end
          1: begin
            sys = pool_sys[pick];
            comp = pool_comp[pick];
            next_seq[pick] = (next_seq[pick] + $urandom_range(0, 255)) % 256;
            seq = next_seq[pick];
          end
          default: begin
            sys = pool_sys[pick];
            comp = pool_comp[pick];
            next_seq[pick] = (next_seq[pick] + 1 + (($urandom_range(0, 5) == 0)
                ? $urandom_range(1, 4) : 0)) % 256;
            seq = next_seq[pick];
          end
        endcase
        send_packet(make_packet(ch, sys, comp, seq, 1'($urandom_range(0, 1))));
        n++;
      end
    end
    in_i.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // End of run.
  initial begin
    wait (stimulus_done || timed_out);
    while (pending_results.size() != 0 && !timed_out) begin
      @(posedge clk_i);
    end
    if (!timed_out) begin
      repeat (100) @(posedge clk_i);
    end
    if (timed_out) begin
      $display("Verification failed");
    end else if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/slm_pkg.sv
sv/slm_if.sv
sv/sequence_loss_monitor.sv
dv/sequence_loss_monitor_test.sv
